// ===== rtl/core/mrf_icm_pkg.sv =====
// ----------------------------------------------------------------------------
// mrf_icm_pkg
// shared types, register codes and the Q4.12 log energy table for the
// iterated-conditional-modes pixel label selector
// ----------------------------------------------------------------------------
package mrf_icm_pkg;

   localparam int MAX_COLORS_DEFAULT = 256;

   localparam int COLOR_WIDTH     = 8;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int NUM_WIDTH       = 9;
   localparam int WEIGHT_WIDTH    = 16;
   localparam int FACTOR_WIDTH    = 16;
   localparam int NB_SUM_WIDTH    = 18;
   localparam int OBS_PROD_WIDTH  = 33;
   localparam int NB_PROD_WIDTH   = 35;
   localparam int ENERGY_WIDTH    = 36;
   localparam int NUM_NEIGHBORS   = 4;

   localparam logic [NUM_WIDTH-1:0]    NUM_COLORS_RESET  = 9'd2;
   localparam logic [WEIGHT_WIDTH-1:0] ETA_WEIGHT_RESET  = 16'd8602;
   localparam logic [WEIGHT_WIDTH-1:0] BETA_WEIGHT_RESET = 16'd4096;

   // request command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NUM_COLORS  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ETA_WEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BETA_WEIGHT = 2'd2;

   // binary-mode energy magnitude, 1.0 in Q4.12
   localparam logic signed [FACTOR_WIDTH-1:0] UNIT_Q12 = 16'sd4096;

   // ln(2) with 64 fraction bits
   localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;
   localparam int LOG_FRAC = 60;
   localparam int LOG_BITS = 40;

   typedef logic [255:0][15:0] ln_tbl_type;

   typedef struct packed {
      logic start;
      logic write;
      logic issue;
      logic capture;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
      logic busy;
   } dp_status_type;

   // round(4096 * ln(d + 1)) for d = 0..255, via log2 by repeated squaring
   function automatic ln_tbl_type build_ln_tbl();
      ln_tbl_type   tbl;
      logic [127:0] y;
      logic [127:0] sq;
      logic [47:0]  lg;
      logic [111:0] prod;
      int           e;
      tbl = '0;
      for (int n = 1; n <= 256; n++) begin
         e = 0;
         for (int k = 1; k <= 8; k++) begin
            if (n >= (1 << k)) begin
               e = k;
            end
         end
         y  = 128'(n) << (LOG_FRAC - e);
         lg = 48'(e) << LOG_BITS;
         for (int i = LOG_BITS - 1; i >= 0; i--) begin
            sq = (y * y) >> LOG_FRAC;
            if (sq >= (128'd2 << LOG_FRAC)) begin
               y     = sq >> 1;
               lg[i] = 1'b1;
            end else begin
               y = sq;
            end
         end
         prod       = 112'(lg) * 112'(LN2_Q64);
         tbl[n - 1] = 16'((prod + (112'd1 << 91)) >> 92);
      end
      return tbl;
   endfunction

   localparam ln_tbl_type LN_TBL = build_ln_tbl();

   // per-term energy factor in Q4.12, the weight is applied later
   function automatic logic signed [FACTOR_WIDTH-1:0] pair_factor(
      input logic [COLOR_WIDTH-1:0] c,
      input logic [COLOR_WIDTH-1:0] y,
      input logic                   two
   );
      logic [COLOR_WIDTH-1:0] d;
      d = (c > y) ? (c - y) : (y - c);
      if (two) begin
         return (c == y) ? -UNIT_Q12 : UNIT_Q12;
      end
      return $signed(LN_TBL[d]);
   endfunction

endpackage

// ===== rtl/core/mrf_icm_pixel_label_select.sv =====
// ----------------------------------------------------------------------------
// mrf_icm_pixel_label_select
// one iterated-conditional-modes label decision for an mrf denoiser
//
// req channel: a beat with cmd load writes one colormap slot; a beat with
// cmd evaluate scans colormap slots 0..num_colors-1 (num_colors clamped to
// 1..MAX_COLORS) and yields one rsp beat carrying the minimum-energy color
// (first slot wins ties). loads produce no rsp beat.
// an evaluate holds req_stall high until its decision is captured: one
// candidate per cycle through the colormap memory read port, then three
// pipeline stages drain before the decision is captured; rsp_valid rises
// on the cycle after. the next req beat can be taken while a decision
// still waits in the rsp register.
// csr port: num_colors (index 0), eta_weight (1), beta_weight (2) are
// written with csr_we; the user must change them only while the block is
// idle (not enforced). reset restores the csr defaults and empties both
// channels; the colormap keeps no reset value and must be loaded before
// use. a stalled rsp beat holds its value; a finished evaluate waits for
// the rsp register to empty before it lets the next req beat in.
// ----------------------------------------------------------------------------
module mrf_icm_pixel_label_select #(
   parameter int MAX_COLORS = mrf_icm_pkg::MAX_COLORS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_cmd,
   input  logic [mrf_icm_pkg::COLOR_WIDTH-1:0]     req_entry_index,
   input  logic [mrf_icm_pkg::COLOR_WIDTH-1:0]     req_entry_color,
   input  logic [mrf_icm_pkg::COLOR_WIDTH-1:0]     req_observed,
   input  logic [mrf_icm_pkg::COLOR_WIDTH-1:0]     req_up_label,
   input  logic [mrf_icm_pkg::COLOR_WIDTH-1:0]     req_down_label,
   input  logic [mrf_icm_pkg::COLOR_WIDTH-1:0]     req_left_label,
   input  logic [mrf_icm_pkg::COLOR_WIDTH-1:0]     req_right_label,
   input  logic                                    req_has_up,
   input  logic                                    req_has_down,
   input  logic                                    req_has_left,
   input  logic                                    req_has_right,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [mrf_icm_pkg::COLOR_WIDTH-1:0]     rsp_chosen_color,
   input  logic                                    csr_we,
   input  logic [mrf_icm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mrf_icm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import mrf_icm_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   mrf_icm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   mrf_icm_dp #(
      .MAX_COLORS (MAX_COLORS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_entry_index  (req_entry_index),
      .req_entry_color  (req_entry_color),
      .req_observed     (req_observed),
      .req_up_label     (req_up_label),
      .req_down_label   (req_down_label),
      .req_left_label   (req_left_label),
      .req_right_label  (req_right_label),
      .req_has_up       (req_has_up),
      .req_has_down     (req_has_down),
      .req_has_left     (req_has_left),
      .req_has_right    (req_has_right),
      .rsp_chosen_color (rsp_chosen_color)
   );

endmodule

// ===== rtl/core/mrf_icm_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrf_icm_ctrl
// sequencer: takes request beats, steps the candidate scan, hands the
// decision to the response register
// ----------------------------------------------------------------------------
module mrf_icm_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_cmd,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output mrf_icm_pkg::dp_cmd_type    dp_cmd,
   input  mrf_icm_pkg::dp_status_type dp_status
);
   import mrf_icm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      dp_cmd       = '0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_EVAL) begin
                  dp_cmd.start = 1'b1;
                  state_in     = ST_RUN;
               end else begin
                  dp_cmd.write = 1'b1;
               end
            end
         end
         ST_RUN: begin
            dp_cmd.issue = 1'b1;
            if (dp_status.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!dp_status.busy && (!rsp_valid_ff || !rsp_stall)) begin
               dp_cmd.capture = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/mrf_icm_dp.sv =====
// ----------------------------------------------------------------------------
// mrf_icm_dp
// datapath: config registers, colormap memory, candidate counter and the
// four-stage energy pipeline with running minimum
// ----------------------------------------------------------------------------
module mrf_icm_dp #(
   parameter int MAX_COLORS = mrf_icm_pkg::MAX_COLORS_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  mrf_icm_pkg::dp_cmd_type                    dp_cmd,
   output mrf_icm_pkg::dp_status_type                 dp_status,
   input  logic                                       csr_we,
   input  logic [mrf_icm_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [mrf_icm_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata,
   input  logic [mrf_icm_pkg::COLOR_WIDTH-1:0]        req_entry_index,
   input  logic [mrf_icm_pkg::COLOR_WIDTH-1:0]        req_entry_color,
   input  logic [mrf_icm_pkg::COLOR_WIDTH-1:0]        req_observed,
   input  logic [mrf_icm_pkg::COLOR_WIDTH-1:0]        req_up_label,
   input  logic [mrf_icm_pkg::COLOR_WIDTH-1:0]        req_down_label,
   input  logic [mrf_icm_pkg::COLOR_WIDTH-1:0]        req_left_label,
   input  logic [mrf_icm_pkg::COLOR_WIDTH-1:0]        req_right_label,
   input  logic                                       req_has_up,
   input  logic                                       req_has_down,
   input  logic                                       req_has_left,
   input  logic                                       req_has_right,
   output logic [mrf_icm_pkg::COLOR_WIDTH-1:0]        rsp_chosen_color
);
   import mrf_icm_pkg::*;

   localparam int AW = $clog2(MAX_COLORS);
   localparam int CW = $clog2(MAX_COLORS + 1);

   // configuration
   logic [NUM_WIDTH-1:0]    num_colors_ff;
   logic [WEIGHT_WIDTH-1:0] eta_ff;
   logic [WEIGHT_WIDTH-1:0] beta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_colors_ff <= NUM_COLORS_RESET;
         eta_ff        <= ETA_WEIGHT_RESET;
         beta_ff       <= BETA_WEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NUM_COLORS:  num_colors_ff <= csr_wdata[NUM_WIDTH-1:0];
            CSR_ETA_WEIGHT:  eta_ff        <= csr_wdata[WEIGHT_WIDTH-1:0];
            CSR_BETA_WEIGHT: beta_ff       <= csr_wdata[WEIGHT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // clamped candidate count
   logic [CW-1:0] count_clamp;

   always_comb begin
      if (num_colors_ff == '0) begin
         count_clamp = CW'(1);
      end else if (32'(num_colors_ff) > MAX_COLORS) begin
         count_clamp = CW'(MAX_COLORS);
      end else begin
         count_clamp = CW'(num_colors_ff);
      end
   end

   // per-pixel operands
   logic [CW-1:0]          count_ff;
   logic                   two_ff;
   logic [COLOR_WIDTH-1:0] obs_ff;
   logic [COLOR_WIDTH-1:0] lab_ff [NUM_NEIGHBORS];
   logic                   has_ff [NUM_NEIGHBORS];

   always_ff @(posedge clock) begin
      if (dp_cmd.start) begin
         count_ff  <= count_clamp;
         two_ff    <= (count_clamp == CW'(2));
         obs_ff    <= req_observed;
         lab_ff[0] <= req_up_label;
         lab_ff[1] <= req_down_label;
         lab_ff[2] <= req_left_label;
         lab_ff[3] <= req_right_label;
         has_ff[0] <= req_has_up;
         has_ff[1] <= req_has_down;
         has_ff[2] <= req_has_left;
         has_ff[3] <= req_has_right;
      end
   end

   // candidate slot counter
   logic [AW-1:0] slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (dp_cmd.start) begin
         slot_ff <= '0;
      end else if (dp_cmd.issue) begin
         slot_ff <= slot_ff + AW'(1);
      end
   end

   // colormap memory, registered read
   logic [COLOR_WIDTH-1:0] color_mem [MAX_COLORS];
   logic [COLOR_WIDTH-1:0] rd_color_ff;
   logic                   entry_ok;

   assign entry_ok = (32'(req_entry_index) < MAX_COLORS);

   always_ff @(posedge clock) begin
      if (dp_cmd.write && entry_ok) begin
         color_mem[req_entry_index[AW-1:0]] <= req_entry_color;
      end
      if (dp_cmd.issue) begin
         rd_color_ff <= color_mem[slot_ff];
      end
   end

   // stage valid and first-candidate tags
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_first_ff, s2_first_ff, s3_first_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= dp_cmd.issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      s1_first_ff <= (slot_ff == '0);
      s2_first_ff <= s1_first_ff;
      s3_first_ff <= s2_first_ff;
   end

   // stage 2: table factors
   logic signed [FACTOR_WIDTH-1:0] obs_f_in;
   logic signed [FACTOR_WIDTH-1:0] nb_f;
   logic signed [NB_SUM_WIDTH-1:0] nb_sum_in;
   logic signed [FACTOR_WIDTH-1:0] obs_f_ff;
   logic signed [NB_SUM_WIDTH-1:0] nb_sum_ff;
   logic [COLOR_WIDTH-1:0]         s2_color_ff;

   always_comb begin
      obs_f_in  = pair_factor(rd_color_ff, obs_ff, two_ff);
      nb_sum_in = '0;
      nb_f      = '0;
      for (int n = 0; n < NUM_NEIGHBORS; n++) begin
         nb_f = pair_factor(rd_color_ff, lab_ff[n], two_ff);
         if (has_ff[n]) begin
            nb_sum_in = nb_sum_in + {{(NB_SUM_WIDTH-FACTOR_WIDTH){nb_f[FACTOR_WIDTH-1]}}, nb_f};
         end
      end
   end

   always_ff @(posedge clock) begin
      obs_f_ff    <= obs_f_in;
      nb_sum_ff   <= nb_sum_in;
      s2_color_ff <= rd_color_ff;
   end

   // stage 3: weighting
   logic signed [OBS_PROD_WIDTH-1:0] obs_prod_ff;
   logic signed [NB_PROD_WIDTH-1:0]  nb_prod_ff;
   logic [COLOR_WIDTH-1:0]           s3_color_ff;

   always_ff @(posedge clock) begin
      obs_prod_ff <= OBS_PROD_WIDTH'($signed({1'b0, eta_ff}) * obs_f_ff);
      nb_prod_ff  <= NB_PROD_WIDTH'($signed({1'b0, beta_ff}) * nb_sum_ff);
      s3_color_ff <= s2_color_ff;
   end

   // stage 4: total and running minimum
   logic signed [ENERGY_WIDTH-1:0] total;
   logic signed [ENERGY_WIDTH-1:0] best_ff;
   logic [COLOR_WIDTH-1:0]         best_color_ff;

   assign total = {{(ENERGY_WIDTH-OBS_PROD_WIDTH){obs_prod_ff[OBS_PROD_WIDTH-1]}}, obs_prod_ff}
                + {{(ENERGY_WIDTH-NB_PROD_WIDTH){nb_prod_ff[NB_PROD_WIDTH-1]}}, nb_prod_ff};

   always_ff @(posedge clock) begin
      if (s3_valid_ff && (s3_first_ff || (total < best_ff))) begin
         best_ff       <= total;
         best_color_ff <= s3_color_ff;
      end
   end

   // response register
   logic [COLOR_WIDTH-1:0] chosen_ff;

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         chosen_ff <= best_color_ff;
      end
   end

   assign rsp_chosen_color = chosen_ff;
   assign dp_status.last   = (CW'(slot_ff) == (count_ff - CW'(1)));
   assign dp_status.busy   = s1_valid_ff | s2_valid_ff | s3_valid_ff;

endmodule
